[rtl/frsp_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and byte-class functions for the FASTA residue stream parser.
// No dependencies; used by every rtl file through scoped names.
package frsp_pkg;

   // Position and sequence length width
   localparam int POS_WIDTH = 32;

   localparam logic       CMD_BYTE = 1'b0;
   localparam logic       CMD_END  = 1'b1;

   localparam logic       MODE_NUC = 1'b0;
   localparam logic       MODE_AA  = 1'b1;

   localparam logic [2:0] KIND_RESIDUE   = 3'd0;
   localparam logic [2:0] KIND_SEPARATOR = 3'd1;
   localparam logic [2:0] KIND_IDENT     = 3'd2;
   localparam logic [2:0] KIND_RECORD    = 3'd3;
   localparam logic [2:0] KIND_ERROR     = 3'd4;
   localparam logic [2:0] KIND_DONE      = 3'd5;

   localparam logic [1:0] ERR_BAD_RESIDUE  = 2'd0;
   localparam logic [1:0] ERR_EMPTY_HEADER = 2'd1;
   localparam logic [1:0] ERR_TOO_MANY     = 2'd2;
   localparam logic [1:0] ERR_NO_SEQUENCES = 2'd3;

   localparam logic [7:0] NUC_LIMIT = 8'd251;
   localparam logic [7:0] AA_LIMIT  = 8'd235;
   localparam logic [7:0] NUC_SHIFT = 8'd4;
   localparam logic [7:0] HDR_MARK  = 8'h3E;
   localparam logic [7:0] NEWLINE   = 8'h0A;
   localparam logic [7:0] CNT_MAX   = 8'hFF;

   typedef logic [POS_WIDTH-1:0] pos_type;

   typedef enum logic [2:0] {
      PH_START,
      PH_HLEAD,
      PH_HID,
      PH_HTAIL,
      PH_SEQ,
      PH_SKIP
   } phase_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  out_byte;
      logic [31:0] position;
      logic [31:0] seq_length;
      logic [7:0]  seq_index;
      logic [1:0]  error_code;
      logic        last_of_run;
   } result_type;

   // Results of one processed beat, in order
   typedef struct packed {
      logic [1:0]  count;
      result_type  slot0;
      result_type  slot1;
   } push_type;

   function automatic result_type make_result(input logic [2:0] kind,
                                              input logic [7:0] byte_val,
                                              input logic [31:0] pos,
                                              input logic [31:0] len,
                                              input logic [7:0] idx,
                                              input logic [1:0] err);
      result_type r;
      r.kind        = kind;
      r.out_byte    = byte_val;
      r.position    = pos;
      r.seq_length  = len;
      r.seq_index   = idx;
      r.error_code  = err;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   function automatic logic is_ws(input logic [7:0] c);
      return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
   endfunction

   // ACDEFGHIKLMNPQRSTVWY
   function automatic logic is_aa(input logic [7:0] c);
      logic hit;
      case (c) inside
         8'h41, [8'h43:8'h49], [8'h4B:8'h4E], [8'h50:8'h54],
         8'h56, 8'h57, 8'h59: hit = 1'b1;
         default:             hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic logic in_alphabet(input logic mode, input logic [7:0] u);
      logic hit;
      if (mode == MODE_AA) begin
         hit = is_aa(u);
      end else begin
         hit = (u == 8'h41) || (u == 8'h43) || (u == 8'h47) || (u == 8'h54);
      end
      return hit;
   endfunction

   // Separator for nucleotide mode: bump past A, C, G, T codes
   function automatic logic [7:0] nuc_sep(input logic [7:0] idx);
      logic [7:0] s;
      s = idx + 8'd1;
      if (s == 8'h41 || s == 8'h43 || s == 8'h47 || s == 8'h54) begin
         s = s + NUC_SHIFT;
      end
      return s;
   endfunction

   // Separator for amino-acid mode: step past a run of letters (longest run is 7)
   function automatic logic [7:0] aa_sep(input logic [7:0] idx);
      logic [7:0] s;
      s = idx + 8'd1;
      for (int i = 0; i < 8; i++) begin
         if (is_aa(s)) begin
            s = s + 8'd1;
         end
      end
      return s;
   endfunction

endpackage

[rtl/fasta_residue_stream_parser.sv]
`timescale 1ns / 1ps
// A request beat is registered in the input stage, then classified into the result
// queue once the queue has room; its first result is offered from the queue head.
// Throughput: one request beat per cycle while the queue has room; a beat that causes
// two results (record plus separator, error or done) hands them out one after the
// other on the single result port. Reset (synchronous, active high): parse state,
// queue and input stage clear; mode is nucleotide.
module fasta_residue_stream_parser (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [7:0]  req_data_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_out_byte,
   output logic [31:0] rsp_position,
   output logic [31:0] rsp_seq_length,
   output logic [7:0]  rsp_seq_index,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_last_of_run,

   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   // Alphabet mode register
   logic mode_ff, mode_in;

   // Input stage: one held beat
   logic       in_valid_ff, in_valid_in;
   logic       in_cmd_ff;
   logic [7:0] in_byte_ff;

   logic                 accept;
   logic                 room;
   logic                 go;
   frsp_pkg::push_type   push;
   frsp_pkg::result_type head;

   // Process the held beat only when the queue can take two results; the
   // stall decision then depends on registered state only.
   assign go          = in_valid_ff && room;
   assign req_stall   = in_valid_ff && !room;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !go);
   assign mode_in     = csr_wr_en ? csr_wr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= frsp_pkg::MODE_NUC;
         in_valid_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         in_valid_ff <= in_valid_in;
      end
   end

   // Payload: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         in_cmd_ff  <= req_command;
         in_byte_ff <= req_data_byte;
      end
   end

   frsp_parse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .mode      (mode_ff),
      .cmd       (in_cmd_ff),
      .data_byte (in_byte_ff),
      .push      (push)
   );

   frsp_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .head      (head),
      .room      (room)
   );

   // Drive the result beat from the queue head
   assign rsp_kind        = head.kind;
   assign rsp_out_byte    = head.out_byte;
   assign rsp_position    = head.position;
   assign rsp_seq_length  = head.seq_length;
   assign rsp_seq_index   = head.seq_index;
   assign rsp_error_code  = head.error_code;
   assign rsp_last_of_run = head.last_of_run;

   // A stall is only ever raised against a held beat
   assert property (@(posedge clock) disable iff (reset) req_stall |-> in_valid_ff)
      else $error("request stall without a held beat");

   // An error result always ends its beat
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == frsp_pkg::KIND_ERROR) |-> rsp_last_of_run)
      else $error("error result not last of its beat");

   // A done result always ends its beat
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == frsp_pkg::KIND_DONE) |-> rsp_last_of_run)
      else $error("done result not last of its beat");

   // Nothing is offered right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

[rtl/frsp_parse_core.sv]
`timescale 1ns / 1ps
// Parse state and the per-beat classification logic; emits up to two results per beat.
// Depends on frsp_pkg.
module frsp_parse_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic               mode,
   input  logic               cmd,
   input  logic [7:0]         data_byte,
   output frsp_pkg::push_type push
);

   frsp_pkg::phase_type phase_ff, phase_in;
   logic                in_seq_ff, in_seq_in;
   frsp_pkg::pos_type   len_ff, len_in;
   frsp_pkg::pos_type   start_ff, start_in;
   frsp_pkg::pos_type   wpos_ff, wpos_in;
   logic [7:0]          cnt_ff, cnt_in;
   logic                err_ff, err_in;

   logic [7:0]             upper;
   logic                   ws;
   logic                   nl;
   logic                   rec_open;
   logic [7:0]             cnt_inc;
   logic [7:0]             cnt_after;
   logic [7:0]             sep_byte;
   logic                   over_limit;
   logic                   take_seq;
   frsp_pkg::result_type   record;
   frsp_pkg::result_type   slot0, slot1;
   logic [1:0]             nres;

   assign upper      = frsp_pkg::to_upper(data_byte);
   assign ws         = frsp_pkg::is_ws(data_byte);
   assign nl         = (data_byte == frsp_pkg::NEWLINE);
   assign rec_open   = in_seq_ff && (len_ff != '0);
   assign cnt_inc    = (cnt_ff != frsp_pkg::CNT_MAX) ? cnt_ff + 8'd1 : cnt_ff;
   assign cnt_after  = rec_open ? cnt_inc : cnt_ff;
   assign sep_byte   = (mode == frsp_pkg::MODE_AA) ? frsp_pkg::aa_sep(cnt_ff)
                                                   : frsp_pkg::nuc_sep(cnt_ff);
   assign over_limit = (mode == frsp_pkg::MODE_AA) ? (cnt_ff >= frsp_pkg::AA_LIMIT)
                                                   : (cnt_ff >= frsp_pkg::NUC_LIMIT);
   assign record     = frsp_pkg::make_result(frsp_pkg::KIND_RECORD, 8'd0, 32'(start_ff),
                                             32'(len_ff), cnt_ff, 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= frsp_pkg::PH_START;
         in_seq_ff <= 1'b0;
         len_ff    <= '0;
         start_ff  <= '0;
         wpos_ff   <= '0;
         cnt_ff    <= '0;
         err_ff    <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         in_seq_ff <= in_seq_in;
         len_ff    <= len_in;
         start_ff  <= start_in;
         wpos_ff   <= wpos_in;
         cnt_ff    <= cnt_in;
         err_ff    <= err_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      in_seq_in = in_seq_ff;
      len_in    = len_ff;
      start_in  = start_ff;
      wpos_in   = wpos_ff;
      cnt_in    = cnt_ff;
      err_in    = err_ff;
      slot0     = '0;
      slot1     = '0;
      nres      = 2'd0;
      take_seq  = 1'b0;

      if (go && !err_ff) begin
         if (cmd == frsp_pkg::CMD_END) begin
            if (phase_ff == frsp_pkg::PH_HLEAD) begin
               slot0  = frsp_pkg::make_result(frsp_pkg::KIND_ERROR, 8'd0, 32'd0, 32'd0,
                                              8'd0, frsp_pkg::ERR_EMPTY_HEADER);
               nres   = 2'd1;
               err_in = 1'b1;
            end else begin
               if (rec_open) begin
                  slot0  = record;
                  cnt_in = cnt_inc;
               end
               if (cnt_after == 8'd0) begin
                  slot0  = frsp_pkg::make_result(frsp_pkg::KIND_ERROR, 8'd0, 32'd0, 32'd0,
                                                 8'd0, frsp_pkg::ERR_NO_SEQUENCES);
                  nres   = 2'd1;
                  err_in = 1'b1;
               end else begin
                  if (rec_open) begin
                     slot1 = frsp_pkg::make_result(frsp_pkg::KIND_DONE, 8'd0, 32'd0,
                                                   32'd0, cnt_after, 2'd0);
                     nres  = 2'd2;
                  end else begin
                     slot0 = frsp_pkg::make_result(frsp_pkg::KIND_DONE, 8'd0, 32'd0,
                                                   32'd0, cnt_after, 2'd0);
                     nres  = 2'd1;
                  end
                  // start over for a new stream
                  phase_in  = frsp_pkg::PH_START;
                  in_seq_in = 1'b0;
                  len_in    = '0;
                  start_in  = '0;
                  wpos_in   = '0;
                  cnt_in    = '0;
               end
            end
         end else begin
            unique case (phase_ff) inside
               frsp_pkg::PH_HLEAD: begin
                  if (nl) begin
                     slot0  = frsp_pkg::make_result(frsp_pkg::KIND_ERROR, 8'd0, 32'd0,
                                                    32'd0, 8'd0, frsp_pkg::ERR_EMPTY_HEADER);
                     nres   = 2'd1;
                     err_in = 1'b1;
                  end else if (!ws) begin
                     in_seq_in = 1'b1;
                     phase_in  = frsp_pkg::PH_HID;
                     slot0     = frsp_pkg::make_result(frsp_pkg::KIND_IDENT, data_byte,
                                                       32'd0, 32'd0, 8'd0, 2'd0);
                     nres      = 2'd1;
                  end
               end
               frsp_pkg::PH_HID: begin
                  if (nl) begin
                     phase_in = frsp_pkg::PH_START;
                  end else if (ws) begin
                     phase_in = frsp_pkg::PH_HTAIL;
                  end else begin
                     slot0 = frsp_pkg::make_result(frsp_pkg::KIND_IDENT, data_byte,
                                                   32'd0, 32'd0, 8'd0, 2'd0);
                     nres  = 2'd1;
                  end
               end
               frsp_pkg::PH_SEQ: begin
                  if (nl) begin
                     phase_in = frsp_pkg::PH_START;
                  end else begin
                     take_seq = 1'b1;
                  end
               end
               frsp_pkg::PH_START: begin
                  if (nl) begin
                     phase_in = frsp_pkg::PH_START;
                  end else if (data_byte == frsp_pkg::HDR_MARK) begin
                     // header closes the open sequence: record, then separator or too-many error
                     if (rec_open) begin
                        slot0  = record;
                        cnt_in = cnt_inc;
                        if (over_limit) begin
                           slot1  = frsp_pkg::make_result(frsp_pkg::KIND_ERROR, 8'd0, 32'd0,
                                                          32'd0, 8'd0, frsp_pkg::ERR_TOO_MANY);
                           err_in = 1'b1;
                        end else begin
                           slot1   = frsp_pkg::make_result(frsp_pkg::KIND_SEPARATOR,
                                                           sep_byte, 32'(wpos_ff), 32'd0,
                                                           cnt_ff, 2'd0);
                           wpos_in = wpos_ff + 1'b1;
                        end
                        nres = 2'd2;
                     end
                     len_in   = '0;
                     start_in = wpos_in;
                     phase_in = frsp_pkg::PH_HLEAD;
                  end else if (in_seq_ff) begin
                     phase_in = frsp_pkg::PH_SEQ;
                     take_seq = 1'b1;
                  end else begin
                     phase_in = frsp_pkg::PH_SKIP;
                  end
               end
               frsp_pkg::PH_HTAIL, frsp_pkg::PH_SKIP: begin
                  if (nl) begin
                     phase_in = frsp_pkg::PH_START;
                  end
               end
               default: begin
                  phase_in = frsp_pkg::PH_START;
               end
            endcase

            if (take_seq && !ws) begin
               if (!frsp_pkg::in_alphabet(mode, upper)) begin
                  slot0  = frsp_pkg::make_result(frsp_pkg::KIND_ERROR, 8'd0, 32'd0, 32'd0,
                                                 8'd0, frsp_pkg::ERR_BAD_RESIDUE);
                  err_in = 1'b1;
               end else begin
                  slot0   = frsp_pkg::make_result(frsp_pkg::KIND_RESIDUE, upper,
                                                  32'(wpos_ff), 32'd0, 8'd0, 2'd0);
                  wpos_in = wpos_ff + 1'b1;
                  len_in  = len_ff + 1'b1;
               end
               nres = 2'd1;
            end
         end
      end

      // flag the final result of the beat
      if (nres == 2'd1) begin
         slot0.last_of_run = 1'b1;
      end
      if (nres == 2'd2) begin
         slot1.last_of_run = 1'b1;
      end

      push.count = nres;
      push.slot0 = slot0;
      push.slot1 = slot1;
   end

endmodule

[rtl/frsp_result_fifo.sv]
`timescale 1ns / 1ps
// Four-entry result queue: takes up to two results per cycle, hands out one unless the output stalls.
// Depends on frsp_pkg.
module frsp_result_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  frsp_pkg::push_type   push,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output frsp_pkg::result_type head,
   output logic                 room
);

   frsp_pkg::result_type mem_ff [4];
   logic [1:0]           wr_ptr_ff, wr_ptr_in;
   logic [1:0]           rd_ptr_ff, rd_ptr_in;
   logic [2:0]           count_ff, count_in;
   logic                 pop;

   assign rsp_valid = (count_ff != 3'd0);
   assign head      = mem_ff[rd_ptr_ff];
   // space for a two-result beat whatever the output side does
   assign room      = (count_ff <= 3'd2);
   assign pop       = rsp_valid && !rsp_stall;

   assign wr_ptr_in = wr_ptr_ff + push.count;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop};
   assign count_in  = count_ff + {1'b0, push.count} - {2'b00, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.slot0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + 2'd1] <= push.slot1;
      end
   end

endmodule

[bench/fasta_parse_checker.sv]
`timescale 1ns / 1ps
// Checker for the FASTA residue stream parser: follows the mode register, predicts the
// results of each request beat and compares response beats in order. Uses frsp_pkg.
module fasta_parse_checker (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_command,
   input  logic [7:0]  req_data_byte,

   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_kind,
   input  logic [7:0]  rsp_out_byte,
   input  logic [31:0] rsp_position,
   input  logic [31:0] rsp_seq_length,
   input  logic [7:0]  rsp_seq_index,
   input  logic [1:0]  rsp_error_code,
   input  logic        rsp_last_of_run,

   input  logic        csr_wr_en,
   input  logic        csr_wr_data,

   output int          mismatch_count,
   output int          outstanding
);
   import frsp_pkg::*;

   localparam logic [1:0] NO_ERROR = 2'd0;

   // Parser state as the block should hold it
   phase_type  line_state;
   logic       seq_open;
   logic       halted;
   logic       mode;
   pos_type    seq_len;
   pos_type    seq_start;
   pos_type    next_pos;
   logic [7:0] closed_count;

   result_type parser_output_q[$];
   int         fails = 0;

   function automatic logic blank(input logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic amino_letter(input logic [7:0] c);
      case (c)
         "A", "C", "D", "E", "F", "G", "H", "I", "K", "L",
         "M", "N", "P", "Q", "R", "S", "T", "V", "W", "Y": return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic legal_residue(input logic [7:0] u);
      if (mode == MODE_AA) return amino_letter(u);
      return u == "A" || u == "C" || u == "G" || u == "T";
   endfunction

   function automatic void emit(input logic [2:0] k, input logic [7:0] b, input pos_type p,
                                input pos_type l, input logic [7:0] i, input logic [1:0] e);
      result_type r;
      r.kind        = k;
      r.out_byte    = b;
      r.position    = p[31:0];
      r.seq_length  = l[31:0];
      r.seq_index   = i;
      r.error_code  = e;
      r.last_of_run = 1'b0;
      parser_output_q.push_back(r);
   endfunction

   function automatic void latch_error(input logic [1:0] code);
      emit(KIND_ERROR, 8'd0, '0, '0, 8'd0, code);
      halted = 1'b1;
   endfunction

   function automatic void restart_stream();
      line_state   = PH_START;
      seq_open     = 1'b0;
      halted       = 1'b0;
      seq_len      = '0;
      seq_start    = '0;
      next_pos     = '0;
      closed_count = 8'd0;
   endfunction

   function automatic void close_record();
      emit(KIND_RECORD, 8'd0, seq_start, seq_len, closed_count, NO_ERROR);
      if (closed_count != CNT_MAX) closed_count++;
   endfunction

   function automatic void take_residue(input logic [7:0] c);
      logic [7:0] u;
      if (blank(c)) return;
      u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
      if (!legal_residue(u)) begin
         latch_error(ERR_BAD_RESIDUE);
         return;
      end
      emit(KIND_RESIDUE, u, next_pos, '0, 8'd0, NO_ERROR);
      next_pos++;
      seq_len++;
   endfunction

   // A header mark at line start: close the open sequence, then place its separator or latch a too-many error
   function automatic void open_header();
      logic [7:0] idx;
      int         sep;
      if (seq_open && seq_len != '0) begin
         idx = closed_count;
         close_record();
         if (mode == MODE_AA) begin
            if (idx >= AA_LIMIT) begin
               latch_error(ERR_TOO_MANY);
               return;
            end
            sep = idx + 1;
            while (amino_letter(8'(sep))) sep++;
         end else begin
            if (idx >= NUC_LIMIT) begin
               latch_error(ERR_TOO_MANY);
               return;
            end
            sep = idx + 1;
            if (sep == "A" || sep == "C" || sep == "G" || sep == "T") sep += NUC_SHIFT;
         end
         emit(KIND_SEPARATOR, 8'(sep), next_pos, '0, idx, NO_ERROR);
         next_pos++;
      end
      seq_len    = '0;
      seq_start  = next_pos;
      line_state = PH_HLEAD;
   endfunction

   function automatic void parse_byte(input logic [7:0] c);
      case (line_state)
         PH_HLEAD: begin
            if (c == NEWLINE) begin
               latch_error(ERR_EMPTY_HEADER);
            end else if (!blank(c)) begin
               seq_open   = 1'b1;
               line_state = PH_HID;
               emit(KIND_IDENT, c, '0, '0, 8'd0, NO_ERROR);
            end
         end
         PH_HID: begin
            if (c == NEWLINE) line_state = PH_START;
            else if (blank(c)) line_state = PH_HTAIL;
            else emit(KIND_IDENT, c, '0, '0, 8'd0, NO_ERROR);
         end
         PH_SEQ: begin
            if (c == NEWLINE) line_state = PH_START;
            else take_residue(c);
         end
         PH_START: begin
            if (c == NEWLINE) begin
            end else if (c == HDR_MARK) begin
               open_header();
            end else if (seq_open) begin
               line_state = PH_SEQ;
               take_residue(c);
            end else begin
               line_state = PH_SKIP;
            end
         end
         default: begin
            if (c == NEWLINE) line_state = PH_START;
         end
      endcase
   endfunction

   function automatic void parse_end();
      if (line_state == PH_HLEAD) begin
         latch_error(ERR_EMPTY_HEADER);
         return;
      end
      if (seq_open && seq_len != '0) close_record();
      if (closed_count == 8'd0) begin
         latch_error(ERR_NO_SEQUENCES);
         return;
      end
      emit(KIND_DONE, 8'd0, '0, '0, closed_count, NO_ERROR);
      restart_stream();
   endfunction

   function automatic void parse_beat(input logic cmd, input logic [7:0] b);
      int         first;
      result_type r;
      if (halted) return;
      first = parser_output_q.size();
      if (cmd == CMD_END) parse_end();
      else parse_byte(b);
      // Flag the final result of this beat
      if (parser_output_q.size() > first) begin
         r = parser_output_q[parser_output_q.size() - 1];
         r.last_of_run = 1'b1;
         parser_output_q[parser_output_q.size() - 1] = r;
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         fails++;
      end
   endfunction

   always @(posedge clock) begin : observe
      result_type want;
      if (reset) begin
         mode = MODE_NUC;
         restart_stream();
         parser_output_q.delete();
      end else begin
         if (csr_wr_en) mode = csr_wr_data;
         if (req_valid && !req_stall) parse_beat(req_command, req_data_byte);
         if (rsp_valid && !rsp_stall) begin
            if (parser_output_q.size() == 0) begin
               $display("%0t: result expected none, actual kind %0d byte %0d position %0d",
                        $time, rsp_kind, rsp_out_byte, rsp_position);
               fails++;
            end else begin
               want = parser_output_q.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("out_byte", want.out_byte, rsp_out_byte);
               check_field("position", want.position, rsp_position);
               check_field("seq_length", want.seq_length, rsp_seq_length);
               check_field("seq_index", want.seq_index, rsp_seq_index);
               check_field("error_code", want.error_code, rsp_error_code);
               check_field("last_of_run", want.last_of_run, rsp_last_of_run);
            end
         end
      end
      mismatch_count <= fails;
      outstanding    <= parser_output_q.size();
   end

endmodule

[bench/fasta_residue_stream_parser_test.sv]
`timescale 1ns / 1ps
// Top of the FASTA residue stream parser bench: clock, reset, byte stimulus, mode writes,
// watchdog and verdict. Depends on frsp_pkg, the parser RTL and fasta_parse_checker.
module fasta_residue_stream_parser_test;
   import frsp_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   // Beats that cause no result may still be in the pipe when the results have drained
   localparam int DRAIN_CYCLES   = 8;
   localparam int SETTLE_CYCLES  = 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = CMD_BYTE;
   logic [7:0]  req_data_byte = 8'd0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_out_byte;
   logic [31:0] rsp_position;
   logic [31:0] rsp_seq_length;
   logic [7:0]  rsp_seq_index;
   logic [1:0]  rsp_error_code;
   logic        rsp_last_of_run;

   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = MODE_NUC;

   int          result_mismatches;
   int          results_in_flight;

   int          beats_sent = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          quiet_cycles = 0;
   logic        cur_mode = MODE_NUC;

   string       nuc_set   = "ACGT";
   string       amino_set = "ACDEFGHIKLMNPQRSTVWY";
   logic [7:0]  blanks [5] = '{8'd9, 8'd11, 8'd12, 8'd13, 8'd32};

   always #6 clock = ~clock;

   fasta_residue_stream_parser DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_position    (rsp_position),
      .rsp_seq_length  (rsp_seq_length),
      .rsp_seq_index   (rsp_seq_index),
      .rsp_error_code  (rsp_error_code),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   fasta_parse_checker parse_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_position    (rsp_position),
      .rsp_seq_length  (rsp_seq_length),
      .rsp_seq_index   (rsp_seq_index),
      .rsp_error_code  (rsp_error_code),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .mismatch_count  (result_mismatches),
      .outstanding     (results_in_flight)
   );

   // Receiver back-pressure: stall at the rate of the current receiver stall setting
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // Watchdog: end the run when neither channel moves a beat for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Random file byte other than newline
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == NEWLINE);
      return b;
   endfunction

   // Random identifier byte: anything but whitespace
   function automatic logic [7:0] id_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == 8'd32 || (b >= 8'd9 && b <= 8'd13));
      return b;
   endfunction

   function automatic logic [7:0] pick_blank();
      return blanks[$urandom_range(0, 4)];
   endfunction

   // Residue of the current alphabet, lower-cased now and then
   function automatic logic [7:0] pick_residue();
      logic [7:0] u;
      if (cur_mode == MODE_AA) u = amino_set[$urandom_range(0, 19)];
      else u = nuc_set[$urandom_range(0, 3)];
      if ($urandom_range(0, 2) == 0) u = u + 8'd32;
      return u;
   endfunction

   // Offer one beat, idling first at the sender's rate, and hold it until accepted.
   // Returns in the time step of the accepting edge with valid still high.
   task automatic send_beat(input logic cmd, input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   // Write the mode only once the parser is idle: drop valid, drain results, let the
   // pipe empty, then pulse the write enable for one edge.
   task automatic set_mode(input logic m);
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_in_flight != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_mode = m;
   endtask

   // Header line: mark, optional leading blanks, identifier, optional ignored tail
   task automatic send_header();
      send_beat(CMD_BYTE, HDR_MARK);
      repeat ($urandom_range(0, 2)) send_beat(CMD_BYTE, pick_blank());
      repeat ($urandom_range(1, 8)) send_beat(CMD_BYTE, id_byte());
      if ($urandom_range(0, 2) == 0) begin
         send_beat(CMD_BYTE, pick_blank());
         repeat ($urandom_range(0, 5)) send_beat(CMD_BYTE, plain_byte());
      end
      send_beat(CMD_BYTE, NEWLINE);
   endtask

   // Line before the first header: any bytes, never led by a header mark
   task automatic send_skip_line();
      logic [7:0] first;
      do first = plain_byte(); while (first == HDR_MARK);
      send_beat(CMD_BYTE, first);
      repeat ($urandom_range(0, 10)) send_beat(CMD_BYTE, plain_byte());
      send_beat(CMD_BYTE, NEWLINE);
   endtask

   // Sequence line of residues and blanks; mostly short, now and then long
   task automatic send_seq_line(input bit need_residue, input bit with_newline);
      int n;
      int i;
      bit got;
      n   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      got = 1'b0;
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 5) == 0) begin
            send_beat(CMD_BYTE, pick_blank());
         end else begin
            send_beat(CMD_BYTE, pick_residue());
            got = 1'b1;
         end
      end
      if (need_residue && !got) send_beat(CMD_BYTE, pick_residue());
      if (with_newline) send_beat(CMD_BYTE, NEWLINE);
   endtask

   // Well-formed stream: optional preamble, nseq sequences (the first one non-empty so
   // the end is a done), empty sequences and empty lines mixed in, then the end command.
   task automatic send_stream(input int nseq);
      int i;
      int j;
      int nlines;
      bit last_line;
      if ($urandom_range(0, 2) == 0) send_skip_line();
      if ($urandom_range(0, 3) == 0) send_beat(CMD_BYTE, NEWLINE);
      for (i = 0; i < nseq; i++) begin
         // Flip the alphabet between sequences once in a while
         if (i > 0 && $urandom_range(0, 19) == 0) set_mode(!cur_mode);
         send_header();
         nlines = $urandom_range(0, 3);
         if (i == 0 && nlines == 0) nlines = 1;
         for (j = 0; j < nlines; j++) begin
            if ($urandom_range(0, 5) == 0) send_beat(CMD_BYTE, NEWLINE);
            last_line = (i == nseq - 1) && (j == nlines - 1);
            send_seq_line(i == 0 && j == 0, !(last_line && $urandom_range(0, 1) == 0));
         end
      end
      send_beat(CMD_END, 8'($urandom_range(0, 255)));
   endtask

   // Many one-residue sequences: walks the separator through high sequence numbers
   task automatic send_dense_stream(input int nseq);
      repeat (nseq) begin
         send_beat(CMD_BYTE, HDR_MARK);
         send_beat(CMD_BYTE, id_byte());
         send_beat(CMD_BYTE, NEWLINE);
         send_beat(CMD_BYTE, pick_residue());
         send_beat(CMD_BYTE, NEWLINE);
      end
      send_beat(CMD_END, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      int   pick;
      logic m;

      // Hold reset, then release it for good
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Phase one idling: sender rarely, receiver mostly
      send_idle_pct  = 7;
      recv_stall_pct <= 75;
      set_mode(MODE_NUC);

      // Directed stream: extreme bytes in a skipped preamble, an empty line, a header
      // with leading blank and top byte as identifier, lower case and blanks in a
      // sequence, record plus separator, whitespace-led line, record plus done.
      send_beat(CMD_BYTE, 8'hFF);
      send_beat(CMD_BYTE, 8'h00);
      send_beat(CMD_BYTE, NEWLINE);
      send_beat(CMD_BYTE, NEWLINE);
      send_beat(CMD_BYTE, HDR_MARK);
      send_beat(CMD_BYTE, 8'd32);
      send_beat(CMD_BYTE, 8'hFF);
      send_beat(CMD_BYTE, NEWLINE);
      send_beat(CMD_BYTE, "a");
      send_beat(CMD_BYTE, "C");
      send_beat(CMD_BYTE, 8'd32);
      send_beat(CMD_BYTE, "g");
      send_beat(CMD_BYTE, "T");
      send_beat(CMD_BYTE, NEWLINE);
      send_beat(CMD_BYTE, HDR_MARK);
      send_beat(CMD_BYTE, "q");
      send_beat(CMD_BYTE, NEWLINE);
      send_beat(CMD_BYTE, 8'd9);
      send_beat(CMD_BYTE, "A");
      send_beat(CMD_END, 8'hFF);

      while (beats_sent < 300) send_stream($urandom_range(1, 6));
      set_mode(MODE_NUC);
      send_dense_stream(90);

      // Phase two: sender mostly idle, receiver rarely stalls, amino acids
      send_idle_pct  = 75;
      recv_stall_pct <= 7;
      set_mode(MODE_AA);
      while (beats_sent < 1050) send_stream($urandom_range(1, 6));
      set_mode(MODE_AA);
      send_dense_stream(90);

      // Phase three: full rate on both sides, random alphabet
      send_idle_pct  = 0;
      recv_stall_pct <= 0;
      set_mode(1'($urandom_range(0, 1)));
      while (beats_sent < 1800) send_stream($urandom_range(1, 6));

      // An error latches until reset, so close the run with exactly one of them
      pick = $urandom_range(0, 3);
      case (pick)
         ERR_BAD_RESIDUE: begin
            send_header();
            if ($urandom_range(0, 1) == 0) begin
               // Header mark inside a whitespace-led line
               send_beat(CMD_BYTE, pick_blank());
               send_beat(CMD_BYTE, HDR_MARK);
            end else begin
               send_beat(CMD_BYTE, 8'h30 + 8'($urandom_range(0, 9)));
            end
         end
         ERR_EMPTY_HEADER: begin
            send_beat(CMD_BYTE, HDR_MARK);
            send_beat(CMD_BYTE, pick_blank());
            if ($urandom_range(0, 1) == 0) send_beat(CMD_BYTE, NEWLINE);
            else send_beat(CMD_END, 8'($urandom_range(0, 255)));
         end
         ERR_TOO_MANY: begin
            m = 1'($urandom_range(0, 1));
            set_mode(m);
            send_dense_stream((m == MODE_AA) ? int'(AA_LIMIT) + 2 : int'(NUC_LIMIT) + 2);
         end
         default: begin
            // No sequences: bare end, or a header whose sequence stays empty
            if ($urandom_range(0, 1) == 0) send_header();
            send_beat(CMD_END, 8'($urandom_range(0, 255)));
         end
      endcase
      // Everything after the error must be swallowed
      repeat (20) send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));

      // Drain, wait out the pipe, then give the verdict
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_in_flight != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (result_mismatches == 0 && results_in_flight == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
